@@ src/terminal_key_escape_decoder_assert.svh @@
// Assertion macros for the terminal key escape decoder.
// Clock i_clk and active-low reset i_rst_n are taken from the enclosing scope.
`ifndef TERMINAL_KEY_ESCAPE_DECODER_ASSERT_SVH
`define TERMINAL_KEY_ESCAPE_DECODER_ASSERT_SVH

`ifndef SYNTHESIS

`define TKED_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

`define TKED_ASSERT_ALL(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`else

`define TKED_ASSERT(lbl, prop, msg)

`define TKED_ASSERT_ALL(lbl, prop, msg)

`endif

`endif

@@ src/tked_pkg.sv @@
package tked_pkg;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_ESC    = 3'd1,
        PH_SS3    = 3'd2,
        PH_CSI    = 3'd3,
        PH_DIGITS = 3'd4
    } t_phase;

    typedef enum logic [4:0] {
        KEY_UNKNOWN = 5'd0,
        KEY_CHAR    = 5'd1,
        KEY_ENTER   = 5'd2,
        KEY_ESC     = 5'd3,
        KEY_BKSP    = 5'd4,
        KEY_TAB     = 5'd5,
        KEY_UP      = 5'd6,
        KEY_DOWN    = 5'd7,
        KEY_LEFT    = 5'd8,
        KEY_RIGHT   = 5'd9,
        KEY_HOME    = 5'd10,
        KEY_END     = 5'd11,
        KEY_PGUP    = 5'd12,
        KEY_PGDN    = 5'd13,
        KEY_DEL     = 5'd14,
        KEY_F1      = 5'd15,
        KEY_F2      = 5'd16
    } t_key;

    localparam logic       KIND_BYTE = 1'b0;
    localparam logic       KIND_TICK = 1'b1;

    localparam logic [7:0] CH_ETX   = 8'd3;
    localparam logic [7:0] CH_BS    = 8'd8;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_ESC   = 8'd27;
    localparam logic [7:0] CH_DEL   = 8'd127;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_O     = 8'h4F;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UB    = 8'h42;
    localparam logic [7:0] CH_UC    = 8'h43;
    localparam logic [7:0] CH_UD    = 8'h44;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_UH    = 8'h48;
    localparam logic [7:0] CH_UP    = 8'h50;
    localparam logic [7:0] CH_UQ    = 8'h51;

    localparam logic [15:0] TIMEOUT_RESET = 16'd30;
    localparam logic [6:0]  NUM_MAX       = 7'd99;

    typedef struct packed {
        t_phase      phase;
        logic [6:0]  num;
        logic [15:0] idle_cnt;
    } t_state;

    typedef struct packed {
        logic       emit;
        t_key       key;
        logic [7:0] chr;
    } t_result;

    function automatic t_key number_key(input logic [6:0] n);
        t_key k;
        begin
            case (n)
                7'd1, 7'd7:  k = KEY_HOME;
                7'd3:        k = KEY_DEL;
                7'd4, 7'd8:  k = KEY_END;
                7'd5:        k = KEY_PGUP;
                7'd6:        k = KEY_PGDN;
                7'd11:       k = KEY_F1;
                7'd12:       k = KEY_F2;
                default:     k = KEY_UNKNOWN;
            endcase
            return k;
        end
    endfunction

endpackage

@@ src/tked_decode.sv @@
module tked_decode (
    input  logic              i_kind,
    input  logic [7:0]        i_byte,
    input  tked_pkg::t_state  i_state,
    input  logic [15:0]       i_timeout,
    output tked_pkg::t_state  o_state,
    output tked_pkg::t_result o_result
);

    logic            is_digit;
    logic [7:0]      digit;
    logic [9:0]      acc10;
    logic [15:0]     limit;
    logic [15:0]     cnt_inc;
    logic            fin;
    tked_pkg::t_key  fin_key;
    tked_pkg::t_state  n_state;
    tked_pkg::t_result res;

    assign is_digit = i_byte inside {[tked_pkg::CH_ZERO:tked_pkg::CH_NINE]};
    assign digit    = i_byte - tked_pkg::CH_ZERO;
    assign acc10    = 10'(i_state.num) * 10'd10 + 10'(digit[3:0]);
    assign limit    = (i_timeout == 16'd0) ? 16'd1 : i_timeout;
    assign cnt_inc  = (i_state.idle_cnt == 16'hFFFF) ? i_state.idle_cnt
                                                       : i_state.idle_cnt + 16'd1;

    always_comb begin
        n_state  = i_state;
        res.emit = 1'b0;
        res.key  = tked_pkg::KEY_UNKNOWN;
        res.chr  = 8'd0;
        fin      = 1'b0;
        fin_key  = tked_pkg::KEY_UNKNOWN;

        if (i_kind == tked_pkg::KIND_TICK) begin
            if (i_state.phase inside {tked_pkg::PH_ESC, tked_pkg::PH_SS3,
                                      tked_pkg::PH_CSI, tked_pkg::PH_DIGITS}) begin
                n_state.idle_cnt = cnt_inc;
                if (cnt_inc >= limit) begin
                    fin     = 1'b1;
                    fin_key = (i_state.phase == tked_pkg::PH_ESC) ? tked_pkg::KEY_ESC
                                                                  : tked_pkg::KEY_UNKNOWN;
                end
            end
        end else begin
            n_state.idle_cnt = 16'd0;
            case (i_state.phase)
                tked_pkg::PH_ESC: begin
                    if (i_byte == tked_pkg::CH_O) begin
                        n_state.phase = tked_pkg::PH_SS3;
                    end else if (i_byte == tked_pkg::CH_LBRK) begin
                        n_state.phase = tked_pkg::PH_CSI;
                    end else begin
                        fin = 1'b1;
                    end
                end
                tked_pkg::PH_SS3: begin
                    fin = 1'b1;
                    case (i_byte)
                        tked_pkg::CH_UP: fin_key = tked_pkg::KEY_F1;
                        tked_pkg::CH_UQ: fin_key = tked_pkg::KEY_F2;
                        tked_pkg::CH_UH: fin_key = tked_pkg::KEY_HOME;
                        tked_pkg::CH_UF: fin_key = tked_pkg::KEY_END;
                        default:         fin_key = tked_pkg::KEY_UNKNOWN;
                    endcase
                end
                tked_pkg::PH_CSI: begin
                    if (is_digit) begin
                        n_state.phase = tked_pkg::PH_DIGITS;
                        n_state.num   = 7'(digit[3:0]);
                    end else begin
                        fin = 1'b1;
                        case (i_byte)
                            tked_pkg::CH_UA: fin_key = tked_pkg::KEY_UP;
                            tked_pkg::CH_UB: fin_key = tked_pkg::KEY_DOWN;
                            tked_pkg::CH_UC: fin_key = tked_pkg::KEY_RIGHT;
                            tked_pkg::CH_UD: fin_key = tked_pkg::KEY_LEFT;
                            tked_pkg::CH_UH: fin_key = tked_pkg::KEY_HOME;
                            tked_pkg::CH_UF: fin_key = tked_pkg::KEY_END;
                            default:         fin_key = tked_pkg::KEY_UNKNOWN;
                        endcase
                    end
                end
                tked_pkg::PH_DIGITS: begin
                    if (is_digit) begin
                        n_state.num = (acc10 > 10'(tked_pkg::NUM_MAX)) ? tked_pkg::NUM_MAX
                                                                        : acc10[6:0];
                    end else begin
                        fin = 1'b1;
                        if (i_byte == tked_pkg::CH_TILDE) begin
                            fin_key = tked_pkg::number_key(i_state.num);
                        end
                    end
                end
                default: begin
                    if (i_byte == tked_pkg::CH_ESC) begin
                        n_state.phase = tked_pkg::PH_ESC;
                        n_state.num   = 7'd0;
                    end else begin
                        n_state.phase = tked_pkg::PH_IDLE;
                        res.emit      = 1'b1;
                        case (i_byte)
                            tked_pkg::CH_CR, tked_pkg::CH_LF: res.key = tked_pkg::KEY_ENTER;
                            tked_pkg::CH_BS, tked_pkg::CH_DEL: res.key = tked_pkg::KEY_BKSP;
                            tked_pkg::CH_TAB: res.key = tked_pkg::KEY_TAB;
                            tked_pkg::CH_ETX: res.key = tked_pkg::KEY_ESC;
                            default: begin
                                if (i_byte inside {[tked_pkg::CH_SPACE:tked_pkg::CH_TILDE]})
                                begin
                                    res.key = tked_pkg::KEY_CHAR;
                                    res.chr = i_byte;
                                end
                            end
                        endcase
                    end
                end
            endcase
        end

        if (fin) begin
            n_state.phase    = tked_pkg::PH_IDLE;
            n_state.num      = 7'd0;
            n_state.idle_cnt = 16'd0;
            res.emit         = 1'b1;
            res.key          = fin_key;
            res.chr          = 8'd0;
        end
    end

    assign o_state  = n_state;
    assign o_result = res;

endmodule

@@ src/terminal_key_escape_decoder.sv @@
// Channel   Direction  Handshake                Payload
// in        input      i_in_valid / o_in_stall  i_kind, i_byte_value
// out       output     o_out_valid / i_out_stall o_key_code, o_char_value
// cfg       input      i_cfg_valid / o_cfg_ready i_cfg_data (timeout_ticks)
//
// One item per cycle while the result register is not stalled; an item passes the input
// register, decode and the result register in that order.
// Sequence state updates as the item leaves the input register.
// Synchronous active-low reset: idle phase, empty registers, timeout 30.
// A stalled result holds; the input keeps flowing while items give no result.
`include "terminal_key_escape_decoder_assert.svh"
module terminal_key_escape_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_kind,
    input  logic [7:0]  i_byte_value,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [4:0]  o_key_code,
    output logic [7:0]  o_char_value,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    logic              r_s1_valid;
    logic              r_s1_kind;
    logic [7:0]        r_s1_byte;
    tked_pkg::t_state  r_state;
    logic [15:0]       r_timeout;
    logic              r_out_valid;
    tked_pkg::t_key    r_out_key;
    logic [7:0]        r_out_chr;

    tked_pkg::t_state  n_state;
    tked_pkg::t_result dec_res;
    logic              out_free;
    logic              s1_fire;
    logic              in_take;

    tked_decode u_decode (
        .i_kind    (r_s1_kind),
        .i_byte    (r_s1_byte),
        .i_state   (r_state),
        .i_timeout (r_timeout),
        .o_state   (n_state),
        .o_result  (dec_res)
    );

    assign out_free    = !r_out_valid || !i_out_stall;
    assign s1_fire     = r_s1_valid && (out_free || !dec_res.emit);
    assign o_in_stall  = r_s1_valid && !s1_fire;
    assign in_take     = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_take) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_kind <= i_kind;
            r_s1_byte <= i_byte_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase    <= tked_pkg::PH_IDLE;
            r_state.num      <= 7'd0;
            r_state.idle_cnt <= 16'd0;
        end else if (s1_fire) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= tked_pkg::TIMEOUT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_timeout <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= s1_fire && dec_res.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && s1_fire && dec_res.emit) begin
            r_out_key <= dec_res.key;
            r_out_chr <= dec_res.chr;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_key_code   = r_out_key;
    assign o_char_value = r_out_chr;

    `TKED_ASSERT(a_idle_clean,
        (r_state.phase == tked_pkg::PH_IDLE) |->
            (r_state.idle_cnt == 16'd0 && r_state.num == 7'd0),
        "idle phase with live sequence counters")
    `TKED_ASSERT(a_num_sat, r_state.num <= tked_pkg::NUM_MAX, "digit value above saturation")
    `TKED_ASSERT(a_char_only,
        o_out_valid |-> ((o_key_code == tked_pkg::KEY_CHAR) == (o_char_value != 8'd0)),
        "char value does not match key code")
    `TKED_ASSERT(a_emit_lands, (s1_fire && dec_res.emit) |=> o_out_valid, "decoded result lost")
    `TKED_ASSERT_ALL(a_stall_busy, o_in_stall |-> r_s1_valid,
        "input stalled with empty input register")

endmodule

@@ sim/terminal_key_escape_decoder_tb.sv @@
`timescale 1ns / 1ps

module terminal_key_escape_decoder_tb;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int PHASE_ITEMS   = 64;
    localparam int MAX_REPORTS   = 10;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_op;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_BURST
    } t_stall_mode;

    typedef struct {
        tked_pkg::t_key key;
        logic [7:0]     chr;
    } t_key_result;

    typedef struct {
        t_row_op        op;
        logic           kind;
        logic [15:0]    arg;
        logic           fixed;
        logic           has;
        tked_pkg::t_key key;
        logic [7:0]     chr;
    } t_dir_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic        i_kind;
    logic [7:0]  i_byte_value;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [4:0]  o_key_code;
    logic [7:0]  o_char_value;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data;

    terminal_key_escape_decoder dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_kind       (i_kind),
        .i_byte_value (i_byte_value),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_key_code   (o_key_code),
        .o_char_value (o_char_value),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // decoder shadow state
    tked_pkg::t_phase key_phase;
    logic [6:0]       key_number;
    logic [15:0]      key_idle;
    logic [15:0]      key_timeout;

    t_key_result expected_keys[$];
    t_key_result got_want;
    t_dir_row    directed_rows[$];

    int          n_items;
    int          n_ticks;
    int          n_results;
    int          n_errors;
    int          n_cfg;
    int          cycles;
    int          burst_left;
    bit          no_idle;

    t_stall_mode stall_mode = STALL_NONE;
    int          stall_mode_left;
    int          stall_run;

    int          settings[8];
    int          phase_start;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, expected_keys.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (stall_mode_left == 0) begin
            stall_mode = t_stall_mode'($urandom_range(0, 3));
            stall_mode_left = $urandom_range(20, 120);
        end else begin
            stall_mode_left--;
        end
        case (stall_mode)
            STALL_NONE:  i_out_stall <= 1'b0;
            STALL_LIGHT: i_out_stall <= ($urandom_range(0, 9) == 0);
            STALL_HEAVY: i_out_stall <= 1'($urandom_range(0, 1));
            default: begin
                if (stall_run > 0) begin
                    stall_run--;
                    i_out_stall <= 1'b1;
                end else if ($urandom_range(0, 15) == 0) begin
                    stall_run = $urandom_range(2, 8);
                    i_out_stall <= 1'b1;
                end else begin
                    i_out_stall <= 1'b0;
                end
            end
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            n_results++;
            if (expected_keys.size() == 0) begin
                n_errors++;
                if (n_errors <= MAX_REPORTS)
                    $display("unexpected key: key %0d char %02h", o_key_code, o_char_value);
            end else begin
                got_want = expected_keys.pop_front();
                if (o_key_code !== got_want.key || o_char_value !== got_want.chr) begin
                    n_errors++;
                    if (n_errors <= MAX_REPORTS)
                        $display("mismatch: expected key %0d char %02h, got key %0d char %02h",
                                 got_want.key, got_want.chr, o_key_code, o_char_value);
                end
            end
        end
    end

    task automatic decode_key(input logic kind, input logic [7:0] b, output logic emit,
                              output tked_pkg::t_key key, output logic [7:0] chr);
        logic [16:0] lim;
        int          v;
        logic        done;
        emit = 1'b0;
        key  = tked_pkg::KEY_UNKNOWN;
        chr  = 8'h00;
        done = 1'b0;
        if (kind == tked_pkg::KIND_TICK) begin
            if (key_phase != tked_pkg::PH_IDLE) begin
                lim = (key_timeout == 16'd0) ? 17'd1 : {1'b0, key_timeout};
                if (key_idle != 16'hFFFF)
                    key_idle++;
                if ({1'b0, key_idle} >= lim) begin
                    emit = 1'b1;
                    done = 1'b1;
                    if (key_phase == tked_pkg::PH_ESC)
                        key = tked_pkg::KEY_ESC;
                end
            end
        end else begin
            key_idle = 16'd0;
            case (key_phase)
                tked_pkg::PH_ESC: begin
                    if (b == tked_pkg::CH_O) begin
                        key_phase = tked_pkg::PH_SS3;
                    end else if (b == tked_pkg::CH_LBRK) begin
                        key_phase = tked_pkg::PH_CSI;
                    end else begin
                        emit = 1'b1;
                        done = 1'b1;
                    end
                end
                tked_pkg::PH_SS3: begin
                    emit = 1'b1;
                    done = 1'b1;
                    case (b)
                        tked_pkg::CH_UP: key = tked_pkg::KEY_F1;
                        tked_pkg::CH_UQ: key = tked_pkg::KEY_F2;
                        tked_pkg::CH_UH: key = tked_pkg::KEY_HOME;
                        tked_pkg::CH_UF: key = tked_pkg::KEY_END;
                        default:         key = tked_pkg::KEY_UNKNOWN;
                    endcase
                end
                tked_pkg::PH_CSI: begin
                    if (b >= tked_pkg::CH_ZERO && b <= tked_pkg::CH_NINE) begin
                        key_number = 7'(b - tked_pkg::CH_ZERO);
                        key_phase = tked_pkg::PH_DIGITS;
                    end else begin
                        emit = 1'b1;
                        done = 1'b1;
                        case (b)
                            tked_pkg::CH_UA: key = tked_pkg::KEY_UP;
                            tked_pkg::CH_UB: key = tked_pkg::KEY_DOWN;
                            tked_pkg::CH_UC: key = tked_pkg::KEY_RIGHT;
                            tked_pkg::CH_UD: key = tked_pkg::KEY_LEFT;
                            tked_pkg::CH_UH: key = tked_pkg::KEY_HOME;
                            tked_pkg::CH_UF: key = tked_pkg::KEY_END;
                            default:         key = tked_pkg::KEY_UNKNOWN;
                        endcase
                    end
                end
                tked_pkg::PH_DIGITS: begin
                    if (b >= tked_pkg::CH_ZERO && b <= tked_pkg::CH_NINE) begin
                        v = key_number * 10 + (b - tked_pkg::CH_ZERO);
                        key_number = (v > 99) ? tked_pkg::NUM_MAX : v[6:0];
                    end else begin
                        emit = 1'b1;
                        done = 1'b1;
                        if (b == tked_pkg::CH_TILDE) begin
                            case (key_number)
                                7'd1, 7'd7: key = tked_pkg::KEY_HOME;
                                7'd3:       key = tked_pkg::KEY_DEL;
                                7'd4, 7'd8: key = tked_pkg::KEY_END;
                                7'd5:       key = tked_pkg::KEY_PGUP;
                                7'd6:       key = tked_pkg::KEY_PGDN;
                                7'd11:      key = tked_pkg::KEY_F1;
                                7'd12:      key = tked_pkg::KEY_F2;
                                default:    key = tked_pkg::KEY_UNKNOWN;
                            endcase
                        end
                    end
                end
                default: begin
                    if (b == tked_pkg::CH_ESC) begin
                        key_phase = tked_pkg::PH_ESC;
                        key_number = 7'd0;
                    end else begin
                        emit = 1'b1;
                        case (b)
                            tked_pkg::CH_CR, tked_pkg::CH_LF:  key = tked_pkg::KEY_ENTER;
                            tked_pkg::CH_BS, tked_pkg::CH_DEL: key = tked_pkg::KEY_BKSP;
                            tked_pkg::CH_TAB:                  key = tked_pkg::KEY_TAB;
                            tked_pkg::CH_ETX:                  key = tked_pkg::KEY_ESC;
                            default: begin
                                if (b >= tked_pkg::CH_SPACE && b <= tked_pkg::CH_TILDE) begin
                                    key = tked_pkg::KEY_CHAR;
                                    chr = b;
                                end
                            end
                        endcase
                    end
                end
            endcase
        end
        if (done) begin
            key_phase = tked_pkg::PH_IDLE;
            key_number = 7'd0;
            key_idle = 16'd0;
        end
    endtask

    task automatic send_item(input logic kind, input logic [7:0] b, input logic fixed,
                             input logic has, input tked_pkg::t_key fkey,
                             input logic [7:0] fchr);
        logic           emit;
        tked_pkg::t_key key;
        logic [7:0]     chr;
        t_key_result    r;
        int             gap;
        i_in_valid   <= 1'b1;
        i_kind       <= kind;
        i_byte_value <= b;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        decode_key(kind, b, emit, key, chr);
        if (fixed) begin
            emit = has;
            key  = fkey;
            chr  = fchr;
        end
        if (emit) begin
            r.key = key;
            r.chr = chr;
            expected_keys.push_back(r);
        end
        n_items++;
        if (kind == tked_pkg::KIND_TICK)
            n_ticks++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 15);
            gap = no_idle ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item(tked_pkg::KIND_BYTE, b, 1'b0, 1'b0, tked_pkg::KEY_UNKNOWN, 8'h00);
    endtask

    task automatic send_tick();
        send_item(tked_pkg::KIND_TICK, 8'($urandom), 1'b0, 1'b0, tked_pkg::KEY_UNKNOWN,
                  8'h00);
    endtask

    task automatic maybe_ticks();
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 2)) send_tick();
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_keys.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_timeout(input logic [15:0] v);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        key_timeout = v;
        n_cfg++;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_sequence();
        int    sel;
        int    n;
        int    k;
        string s;
        logic [7:0] letters[6];
        sel = $urandom_range(0, 99);
        if (sel < 20) begin
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
        end else if (sel < 32) begin
            letters = '{tked_pkg::CH_UP, tked_pkg::CH_UQ, tked_pkg::CH_UH, tked_pkg::CH_UF,
                        tked_pkg::CH_UP, tked_pkg::CH_UQ};
            send_byte(tked_pkg::CH_ESC);
            maybe_ticks();
            send_byte(tked_pkg::CH_O);
            maybe_ticks();
            if ($urandom_range(0, 4) == 0)
                send_byte(8'($urandom));
            else
                send_byte(letters[$urandom_range(0, 5)]);
        end else if (sel < 47) begin
            letters = '{tked_pkg::CH_UA, tked_pkg::CH_UB, tked_pkg::CH_UC, tked_pkg::CH_UD,
                        tked_pkg::CH_UH, tked_pkg::CH_UF};
            send_byte(tked_pkg::CH_ESC);
            maybe_ticks();
            send_byte(tked_pkg::CH_LBRK);
            maybe_ticks();
            if ($urandom_range(0, 4) == 0)
                send_byte(8'($urandom));
            else
                send_byte(letters[$urandom_range(0, 5)]);
        end else if (sel < 67) begin
            case ($urandom_range(0, 9))
                0: n = $urandom_range(0, 999);
                1: n = $urandom_range(100, 99999);
                default: begin
                    case ($urandom_range(0, 8))
                        0: n = 1;
                        1: n = 3;
                        2: n = 4;
                        3: n = 5;
                        4: n = 6;
                        5: n = 7;
                        6: n = 8;
                        7: n = 11;
                        default: n = 12;
                    endcase
                end
            endcase
            s = $sformatf("%0d", n);
            send_byte(tked_pkg::CH_ESC);
            send_byte(tked_pkg::CH_LBRK);
            for (k = 0; k < s.len(); k++) begin
                maybe_ticks();
                send_byte(s[k]);
            end
            if ($urandom_range(0, 6) == 0)
                send_byte(8'($urandom));
            else
                send_byte(tked_pkg::CH_TILDE);
        end else if (sel < 77) begin
            send_byte(tked_pkg::CH_ESC);
            case ($urandom_range(0, 3))
                0: send_byte(tked_pkg::CH_O);
                1: send_byte(tked_pkg::CH_LBRK);
                2: begin
                    send_byte(tked_pkg::CH_LBRK);
                    send_byte(tked_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
                end
                default: ;
            endcase
            if (key_timeout <= 16'd40)
                k = key_timeout + $urandom_range(0, 1);
            else
                k = $urandom_range(1, 40);
            if (k < 1)
                k = 1;
            repeat (k) send_tick();
        end else if (sel < 85) begin
            send_byte(tked_pkg::CH_ESC);
            if ($urandom_range(0, 3) == 0)
                send_byte(tked_pkg::CH_ESC);
            else
                send_byte(8'($urandom));
        end else begin
            repeat ($urandom_range(1, 4)) send_item(1'($urandom), 8'($urandom), 1'b0, 1'b0,
                                                  tked_pkg::KEY_UNKNOWN, 8'h00);
        end
    endtask

    function automatic t_dir_row pred_row(input logic kind, input logic [7:0] b);
        t_dir_row r;
        r.op    = ROW_ITEM;
        r.kind  = kind;
        r.arg   = {8'h00, b};
        r.fixed = 1'b0;
        r.has   = 1'b0;
        r.key   = tked_pkg::KEY_UNKNOWN;
        r.chr   = 8'h00;
        return r;
    endfunction

    function automatic t_dir_row fixed_row(input logic kind, input logic [7:0] b,
                                           input logic has, input tked_pkg::t_key key,
                                           input logic [7:0] chr);
        t_dir_row r;
        r = pred_row(kind, b);
        r.fixed = 1'b1;
        r.has   = has;
        r.key   = key;
        r.chr   = chr;
        return r;
    endfunction

    function automatic t_dir_row cfg_row(input logic [15:0] v);
        t_dir_row r;
        r = pred_row(tked_pkg::KIND_BYTE, 8'h00);
        r.op  = ROW_CFG;
        r.arg = v;
        return r;
    endfunction

    initial begin
        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_kind       <= tked_pkg::KIND_BYTE;
        i_byte_value <= 8'h00;
        i_cfg_valid  <= 1'b0;
        i_cfg_data   <= 16'h0000;
        key_phase    = tked_pkg::PH_IDLE;
        key_number   = 7'd0;
        key_idle     = 16'd0;
        key_timeout  = tked_pkg::TIMEOUT_RESET;

        // plain bytes from reset, then the short sequences
        directed_rows.push_back(fixed_row(tked_pkg::KIND_BYTE, tked_pkg::CH_CR, 1'b1,
                                          tked_pkg::KEY_ENTER, 8'h00));
        directed_rows.push_back(fixed_row(tked_pkg::KIND_BYTE, tked_pkg::CH_LF, 1'b1,
                                          tked_pkg::KEY_ENTER, 8'h00));
        directed_rows.push_back(fixed_row(tked_pkg::KIND_BYTE, tked_pkg::CH_BS, 1'b1,
                                          tked_pkg::KEY_BKSP, 8'h00));
        directed_rows.push_back(fixed_row(tked_pkg::KIND_BYTE, tked_pkg::CH_DEL, 1'b1,
                                          tked_pkg::KEY_BKSP, 8'h00));
        directed_rows.push_back(fixed_row(tked_pkg::KIND_BYTE, tked_pkg::CH_TAB, 1'b1,
                                          tked_pkg::KEY_TAB, 8'h00));
        directed_rows.push_back(fixed_row(tked_pkg::KIND_BYTE, tked_pkg::CH_ETX, 1'b1,
                                          tked_pkg::KEY_ESC, 8'h00));
        directed_rows.push_back(fixed_row(tked_pkg::KIND_BYTE, tked_pkg::CH_SPACE, 1'b1,
                                          tked_pkg::KEY_CHAR, tked_pkg::CH_SPACE));
        directed_rows.push_back(fixed_row(tked_pkg::KIND_BYTE, tked_pkg::CH_TILDE, 1'b1,
                                          tked_pkg::KEY_CHAR, tked_pkg::CH_TILDE));
        directed_rows.push_back(fixed_row(tked_pkg::KIND_BYTE, 8'h00, 1'b1,
                                          tked_pkg::KEY_UNKNOWN, 8'h00));
        directed_rows.push_back(fixed_row(tked_pkg::KIND_BYTE, 8'hFF, 1'b1,
                                          tked_pkg::KEY_UNKNOWN, 8'h00));
        directed_rows.push_back(fixed_row(tked_pkg::KIND_TICK, 8'hA5, 1'b0,
                                          tked_pkg::KEY_UNKNOWN, 8'h00));
        directed_rows.push_back(pred_row(tked_pkg::KIND_BYTE, tked_pkg::CH_ESC));
        directed_rows.push_back(pred_row(tked_pkg::KIND_BYTE, tked_pkg::CH_O));
        directed_rows.push_back(pred_row(tked_pkg::KIND_BYTE, tked_pkg::CH_UP));
        directed_rows.push_back(pred_row(tked_pkg::KIND_BYTE, tked_pkg::CH_ESC));
        directed_rows.push_back(pred_row(tked_pkg::KIND_BYTE, tked_pkg::CH_LBRK));
        directed_rows.push_back(pred_row(tked_pkg::KIND_BYTE, tked_pkg::CH_TILDE));
        directed_rows.push_back(pred_row(tked_pkg::KIND_BYTE, tked_pkg::CH_ESC));
        directed_rows.push_back(pred_row(tked_pkg::KIND_BYTE, tked_pkg::CH_ESC));
        directed_rows.push_back(pred_row(tked_pkg::KIND_BYTE, tked_pkg::CH_ESC));
        directed_rows.push_back(pred_row(tked_pkg::KIND_BYTE, tked_pkg::CH_LBRK));
        directed_rows.push_back(pred_row(tked_pkg::KIND_BYTE, tked_pkg::CH_NINE));
        directed_rows.push_back(pred_row(tked_pkg::KIND_BYTE, tked_pkg::CH_NINE));
        directed_rows.push_back(pred_row(tked_pkg::KIND_BYTE, tked_pkg::CH_NINE));
        directed_rows.push_back(pred_row(tked_pkg::KIND_BYTE, tked_pkg::CH_TILDE));
        // zero timeout behaves as one tick
        directed_rows.push_back(cfg_row(16'd0));
        directed_rows.push_back(pred_row(tked_pkg::KIND_BYTE, tked_pkg::CH_ESC));
        directed_rows.push_back(fixed_row(tked_pkg::KIND_TICK, 8'h5A, 1'b1,
                                          tked_pkg::KEY_ESC, 8'h00));
        directed_rows.push_back(cfg_row(16'd1));
        directed_rows.push_back(pred_row(tked_pkg::KIND_BYTE, tked_pkg::CH_ESC));
        directed_rows.push_back(pred_row(tked_pkg::KIND_BYTE, tked_pkg::CH_LBRK));
        directed_rows.push_back(fixed_row(tked_pkg::KIND_TICK, 8'hFF, 1'b1,
                                          tked_pkg::KEY_UNKNOWN, 8'h00));

        settings = '{1, 0, 2, 65535, 3, 30, 0, 0};
        settings[6] = $urandom_range(1, 24);
        settings[7] = $urandom_range(0, 65535);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].op == ROW_CFG)
                write_timeout(directed_rows[i].arg);
            else
                send_item(directed_rows[i].kind, directed_rows[i].arg[7:0],
                          directed_rows[i].fixed, directed_rows[i].has,
                          directed_rows[i].key, directed_rows[i].chr);
        end

        foreach (settings[i]) begin
            write_timeout(settings[i][15:0]);
            no_idle = (i == 2);
            phase_start = n_items;
            while (n_items - phase_start < PHASE_ITEMS)
                random_sequence();
        end

        drain();
        $display("%0d items (%0d ticks), %0d keys checked, %0d timeout settings",
                 n_items, n_ticks, n_results, n_cfg);
        $display("%0d mismatches", n_errors);
        if (n_errors == 0 && expected_keys.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+src
src/tked_pkg.sv
src/tked_decode.sv
src/terminal_key_escape_decoder.sv
sim/terminal_key_escape_decoder_tb.sv
